// File: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define VGMCSP_ASSERT_NOW(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("vgmcsp assertion failed");

// next-cycle implication
`define VGMCSP_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("vgmcsp assertion failed");

`endif

// File: design/vgmcsp_pkg.sv
package vgmcsp_pkg;

	localparam int BLOCK_COUNT_BITS = 31;
	localparam int QUEUE_DEPTH      = 4;
	localparam int QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);

	localparam logic [2:0] EV_WAIT  = 3'd0;
	localparam logic [2:0] EV_WRITE = 3'd1;
	localparam logic [2:0] EV_END   = 3'd2;
	localparam logic [2:0] EV_MASK  = 3'd3;
	localparam logic [2:0] EV_ERROR = 3'd4;

	localparam logic [1:0] ERR_OPCODE    = 2'd0;
	localparam logic [1:0] ERR_CMD_CUT   = 2'd1;
	localparam logic [1:0] ERR_BLOCK_CUT = 2'd2;

	localparam logic [7:0] OP_STEREO  = 8'h31;
	localparam logic [7:0] OP_WAIT16  = 8'h61;
	localparam logic [7:0] OP_WAIT735 = 8'h62;
	localparam logic [7:0] OP_WAIT882 = 8'h63;
	localparam logic [7:0] OP_END     = 8'h66;
	localparam logic [7:0] OP_BLOCK   = 8'h67;

	typedef struct packed {
		logic [7:0] stream_byte;
		logic       final_byte;
	} byte_item_t;

	typedef struct packed {
		logic [2:0]  event_kind;
		logic [4:0]  chip_id;
		logic [7:0]  port_number;
		logic [15:0] register_address;
		logic [15:0] write_value;
		logic [15:0] wait_samples;
		logic [1:0]  error_code;
	} event_item_t;

	typedef struct packed {
		logic        is_error;
		logic [1:0]  error_code;
		logic [7:0]  opcode;
		logic [31:0] operands;
	} cmd_rec_t;

endpackage

// File: design/vgmcsp_front.sv
module vgmcsp_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_stall,
	input  vgmcsp_pkg::byte_item_t byte_item,
	input  logic                  queue_full,
	output logic                  push,
	output vgmcsp_pkg::cmd_rec_t  push_rec
);
	import vgmcsp_pkg::*;

	function automatic logic [3:0] cmd_size(input logic [7:0] op);
		logic [3:0] sz;
		unique case (op) inside
			[8'h30:8'h3f]:          sz = 4'd2;
			[8'h40:8'h4e]:          sz = 4'd3;
			8'h4f, 8'h50:           sz = 4'd2;
			[8'h51:8'h5f]:          sz = 4'd3;
			OP_WAIT16:              sz = 4'd3;
			OP_WAIT735, OP_WAIT882,
			OP_END:                 sz = 4'd1;
			8'h64:                  sz = 4'd4;
			OP_BLOCK:               sz = 4'd7;
			8'h68:                  sz = 4'd12;
			[8'h70:8'h8f]:          sz = 4'd1;
			8'h90, 8'h91, 8'h95:    sz = 4'd5;
			8'h92:                  sz = 4'd6;
			8'h93:                  sz = 4'd11;
			8'h94:                  sz = 4'd2;
			[8'ha0:8'hbf]:          sz = 4'd3;
			[8'hc0:8'hdf]:          sz = 4'd4;
			[8'he0:8'hff]:          sz = 4'd5;
			default:                sz = 4'd0;
		endcase
		return sz;
	endfunction

	logic                        halted_q, halted_n;
	logic [7:0]                  opcode_q, opcode_n;
	logic [3:0]                  need_q, need_n;
	logic [31:0]                 operand_q, operand_n;
	logic [BLOCK_COUNT_BITS-1:0] remain_q, remain_n;
	logic                        skip_q, skip_n;

	logic        accept;
	logic [7:0]  b;
	logic        fin;
	logic [3:0]  size_new, size_cur, idx, need_dec;
	logic [31:0] op_upd;
	logic [BLOCK_COUNT_BITS-1:0] blk_len;
	logic        raise;
	logic [1:0]  raise_code;

	assign byte_stall = queue_full;
	assign accept     = byte_valid && !byte_stall;
	assign b          = byte_item.stream_byte;
	assign fin        = byte_item.final_byte;
	assign size_new   = cmd_size(b);
	assign size_cur   = cmd_size(opcode_q);
	assign idx        = size_cur - 4'd1 - need_q;
	assign need_dec   = need_q - 4'd1;
	assign blk_len    = op_upd[BLOCK_COUNT_BITS-1:0];

	always_comb begin
		op_upd = operand_q;
		if (opcode_q == OP_BLOCK) begin
			op_upd = {b, operand_q[31:8]};
		end else begin
			case (idx)
				4'd0:    op_upd[7:0]   = b;
				4'd1:    op_upd[15:8]  = b;
				4'd2:    op_upd[23:16] = b;
				4'd3:    op_upd[31:24] = b;
				default: op_upd        = operand_q;
			endcase
		end
	end

	always_comb begin
		halted_n   = halted_q;
		opcode_n   = opcode_q;
		need_n     = need_q;
		operand_n  = operand_q;
		remain_n   = remain_q;
		skip_n     = skip_q;
		raise      = 1'b0;
		raise_code = ERR_OPCODE;
		push       = 1'b0;
		push_rec   = '{is_error: 1'b0, error_code: ERR_OPCODE, opcode: opcode_q,
			operands: op_upd};
		if (accept && !halted_q) begin
			if (skip_q) begin
				remain_n = remain_q - BLOCK_COUNT_BITS'(1);
				if (remain_q == BLOCK_COUNT_BITS'(1)) begin
					skip_n = 1'b0;
				end else if (fin) begin
					raise      = 1'b1;
					raise_code = ERR_BLOCK_CUT;
				end
			end else if (need_q == 4'd0) begin
				if (size_new == 4'd0) begin
					raise      = 1'b1;
					raise_code = ERR_OPCODE;
				end else begin
					opcode_n  = b;
					operand_n = '0;
					if (size_new == 4'd1) begin
						push              = 1'b1;
						push_rec.opcode   = b;
						push_rec.operands = '0;
						if (b == OP_END) begin
							halted_n = 1'b1;
						end
					end else if (fin) begin
						raise      = 1'b1;
						raise_code = ERR_CMD_CUT;
					end else begin
						need_n = size_new - 4'd1;
					end
				end
			end else begin
				operand_n = op_upd;
				need_n    = need_dec;
				if (need_dec != 4'd0) begin
					if (fin) begin
						raise      = 1'b1;
						raise_code = ERR_CMD_CUT;
					end
				end else if (opcode_q == OP_BLOCK) begin
					if (blk_len != '0) begin
						skip_n   = 1'b1;
						remain_n = blk_len;
						if (fin) begin
							raise      = 1'b1;
							raise_code = ERR_BLOCK_CUT;
						end
					end
				end else begin
					push = 1'b1;
				end
			end
			if (raise) begin
				push                = 1'b1;
				push_rec.is_error   = 1'b1;
				push_rec.error_code = raise_code;
				halted_n            = 1'b1;
				need_n              = 4'd0;
				skip_n              = 1'b0;
				remain_n            = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halted_q  <= 1'b0;
			opcode_q  <= '0;
			need_q    <= '0;
			operand_q <= '0;
			remain_q  <= '0;
			skip_q    <= 1'b0;
		end else if (accept) begin
			halted_q  <= halted_n;
			opcode_q  <= opcode_n;
			need_q    <= need_n;
			operand_q <= operand_n;
			remain_q  <= remain_n;
			skip_q    <= skip_n;
		end
	end

endmodule

// File: design/vgmcsp_queue.sv
module vgmcsp_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  vgmcsp_pkg::cmd_rec_t push_rec,
	output logic                 full,
	input  logic                 pop,
	output logic                 not_empty,
	output vgmcsp_pkg::cmd_rec_t head_rec
);
	import vgmcsp_pkg::*;

	cmd_rec_t                  ent_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_PTR_BITS:0]   count_q;
	logic                      do_push, do_pop;

	assign full      = count_q == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign head_rec  = ent_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_PTR_BITS'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_BITS'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (QUEUE_PTR_BITS+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (QUEUE_PTR_BITS+1)'(1);
			end
		end
	end

endmodule

// File: design/vgmcsp_back.sv
module vgmcsp_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    not_empty,
	input  vgmcsp_pkg::cmd_rec_t    head_rec,
	output logic                    pop,
	output logic                    event_valid,
	input  logic                    event_stall,
	output vgmcsp_pkg::event_item_t event_item
);
	import vgmcsp_pkg::*;

	event_item_t evt_q, evt_n;
	logic        evt_valid_q;
	logic        has_event;
	logic [7:0]  op, b1, b2, b3, b4;

	assign op  = head_rec.opcode;
	assign b1  = head_rec.operands[7:0];
	assign b2  = head_rec.operands[15:8];
	assign b3  = head_rec.operands[23:16];
	assign b4  = head_rec.operands[31:24];
	assign pop = not_empty && (!evt_valid_q || !event_stall);

	always_comb begin
		evt_n     = '0;
		has_event = 1'b1;
		if (head_rec.is_error) begin
			evt_n.event_kind = EV_ERROR;
			evt_n.error_code = head_rec.error_code;
		end else begin
			unique case (op) inside
				[8'h70:8'h7f]: evt_n.wait_samples = {12'd0, op[3:0]} + 16'd1;
				[8'h80:8'h8f]: evt_n.wait_samples = {12'd0, op[3:0]};
				OP_WAIT16:     evt_n.wait_samples = {b2, b1};
				OP_WAIT735:    evt_n.wait_samples = 16'd735;
				OP_WAIT882:    evt_n.wait_samples = 16'd882;
				OP_END:        evt_n.event_kind = EV_END;
				OP_STEREO: begin
					evt_n.event_kind  = EV_MASK;
					evt_n.chip_id     = {4'd0, b1[7]};
					evt_n.write_value = {8'd0, b1};
				end
				[8'h51:8'h5f]: begin
					evt_n.event_kind       = EV_WRITE;
					evt_n.register_address = {8'd0, b1};
					evt_n.write_value      = {8'd0, b2};
					case (op[3:0])
						4'h1:       evt_n.chip_id = 5'd2;
						4'h2, 4'h3: evt_n.chip_id = 5'd3;
						4'h4:       evt_n.chip_id = 5'd4;
						4'h5:       evt_n.chip_id = 5'd5;
						4'h6, 4'h7: evt_n.chip_id = 5'd6;
						4'h8, 4'h9: evt_n.chip_id = 5'd7;
						4'ha:       evt_n.chip_id = 5'd8;
						4'hb:       evt_n.chip_id = 5'd9;
						4'hc:       evt_n.chip_id = 5'd10;
						4'hd:       evt_n.chip_id = 5'd11;
						default:    evt_n.chip_id = 5'd12;
					endcase
					case (op[3:0])
						4'h3, 4'h7, 4'h9, 4'hf: evt_n.port_number = 8'd1;
						default:                evt_n.port_number = 8'd0;
					endcase
				end
				8'hd0, 8'hd1, 8'hd2: begin
					evt_n.event_kind       = EV_WRITE;
					evt_n.chip_id          = 5'(op[1:0]) + 5'd13;
					evt_n.port_number      = b1;
					evt_n.register_address = {8'd0, b2};
					evt_n.write_value      = {8'd0, b3};
				end
				8'hd3, 8'hd4, 8'hd5: begin
					evt_n.event_kind       = EV_WRITE;
					evt_n.chip_id          = 5'(op[2:0]) + 5'd13;
					evt_n.register_address = {b2, b1};
					evt_n.write_value      = {8'd0, b3};
				end
				8'hd6: begin
					evt_n.event_kind       = EV_WRITE;
					evt_n.chip_id          = 5'd19;
					evt_n.register_address = {8'd0, b1};
					evt_n.write_value      = {b3, b2};
				end
				8'he1: begin
					evt_n.event_kind       = EV_WRITE;
					evt_n.chip_id          = 5'd20;
					evt_n.register_address = {b2, b1};
					evt_n.write_value      = {b4, b3};
				end
				default: has_event = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop && has_event) begin
			evt_q <= evt_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_q <= 1'b0;
		end else if (pop) begin
			evt_valid_q <= has_event;
		end else if (!event_stall) begin
			evt_valid_q <= 1'b0;
		end
	end

	assign event_valid = evt_valid_q;
	assign event_item  = evt_q;

endmodule

// File: design/vgm_command_stream_parser_unit.sv
// channel  | direction | handshake                 | payload
// byte     | in        | byte_valid / byte_stall   | byte_item  (stream_byte, final_byte)
// event    | out       | event_valid / event_stall | event_item (event_kind .. error_code)
//
// One byte is taken per cycle while byte_stall is low; the byte parser's counters are registered on each accepted byte.
// A completed command reaches event_item through a four-entry command queue and then
// the registered decode stage.
// byte_stall rises only while the command queue is full; that happens when event_stall
// holds the output register while further commands keep arriving.
// Reset clears all parser state and empties the queue; there is no clearing pass.
module vgm_command_stream_parser_unit (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    byte_valid,
	output logic                    byte_stall,
	input  vgmcsp_pkg::byte_item_t  byte_item,
	output logic                    event_valid,
	input  logic                    event_stall,
	output vgmcsp_pkg::event_item_t event_item
);
	import vgmcsp_pkg::*;

	logic     push, queue_full, pop, not_empty;
	cmd_rec_t push_rec, head_rec;

	vgmcsp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.queue_full (queue_full),
		.push       (push),
		.push_rec   (push_rec)
	);

	vgmcsp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_rec  (push_rec),
		.full      (queue_full),
		.pop       (pop),
		.not_empty (not_empty),
		.head_rec  (head_rec)
	);

	vgmcsp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.not_empty   (not_empty),
		.head_rec    (head_rec),
		.pop         (pop),
		.event_valid (event_valid),
		.event_stall (event_stall),
		.event_item  (event_item)
	);

endmodule

// File: design/vgmcsp_checker.sv
`include "assert_macros.svh"

module vgmcsp_checker (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    event_valid,
	input logic                    event_stall,
	input vgmcsp_pkg::event_item_t event_item
);
	import vgmcsp_pkg::*;

	logic last_transfer;
	logic other_kind, code_clear, wait_shown, write_clear;

	assign last_transfer = event_valid && !event_stall &&
		(event_item.event_kind == EV_END || event_item.event_kind == EV_ERROR);
	assign other_kind  = event_valid && event_item.event_kind != EV_ERROR;
	assign code_clear  = event_item.error_code == ERR_OPCODE;
	assign wait_shown  = event_valid && event_item.event_kind == EV_WAIT;
	assign write_clear = event_item.register_address == 16'd0 &&
		event_item.write_value == 16'd0 && event_item.chip_id == 5'd0;

	`VGMCSP_ASSERT_NEXT(a_valid_holds, clk, arst_n, event_valid && event_stall, event_valid)
	`VGMCSP_ASSERT_NEXT(a_item_holds, clk, arst_n, event_valid && event_stall, $stable(event_item))
	`VGMCSP_ASSERT_NEXT(a_silent_after_halt, clk, arst_n, last_transfer, !event_valid)
	`VGMCSP_ASSERT_NOW(a_error_code_only_on_error, clk, arst_n, other_kind, code_clear)
	`VGMCSP_ASSERT_NOW(a_wait_has_no_write, clk, arst_n, wait_shown, write_clear)

endmodule

bind vgm_command_stream_parser_unit vgmcsp_checker u_vgmcsp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.event_valid (event_valid),
	.event_stall (event_stall),
	.event_item  (event_item)
);
